FILE: rtl/bpwm_pkg.sv
// ============================================================================
// bpwm_pkg
// Shared types, register indexes and reset values of the breathing PWM core.
// ============================================================================
`default_nettype none

package bpwm_pkg;

    // Counter and compare width
    localparam int CNT_W   = 16;
    // Prescaler width (fixed by the prescale_div register)
    localparam int PRE_W   = 16;
    // Configuration register index width
    localparam int CFG_IDX_W = 3;
    // Configuration write data width
    localparam int CFG_DATA_W = 16;

    // Initial pulse value for active and preloaded compare
    localparam logic [CNT_W-1:0] INIT_PULSE = CNT_W'(1000);

    // Register reset values
    localparam logic [PRE_W-1:0] RST_PRESCALE_DIV = PRE_W'(1679);
    localparam logic [CNT_W-1:0] RST_PERIOD_TOP   = CNT_W'(999);
    localparam logic [CNT_W-1:0] RST_DUTY_STEP    = CNT_W'(5);
    localparam logic [CNT_W-1:0] RST_DUTY_LIMIT   = CNT_W'(1000);
    localparam logic             RST_MODE_TWO     = 1'b1;
    localparam logic             RST_POLARITY_LOW = 1'b0;
    localparam logic             RST_OUTPUT_EN    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESCALE_DIV  = 3'd0,
        REG_PERIOD_TOP    = 3'd1,
        REG_DUTY_STEP     = 3'd2,
        REG_DUTY_LIMIT    = 3'd3,
        REG_MODE_TWO      = 3'd4,
        REG_POLARITY_LOW  = 3'd5,
        REG_OUTPUT_ENABLE = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [PRE_W-1:0] prescale_div;
        logic [CNT_W-1:0] period_top;
        logic [CNT_W-1:0] duty_step;
        logic [CNT_W-1:0] duty_limit;
        logic             mode_two;
        logic             polarity_low;
        logic             output_enable;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/bpwm_cfg_regs.sv
// ============================================================================
// bpwm_cfg_regs
// Configuration register file; every write transfer is taken at once.
// ============================================================================
`default_nettype none

module bpwm_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bpwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bpwm_pkg::CFG_DATA_W-1:0] cfg_data,
    output bpwm_pkg::cfg_t                      cfg
);
    import bpwm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_PRESCALE_DIV:  cfg_next.prescale_div  = cfg_data[PRE_W-1:0];
                REG_PERIOD_TOP:    cfg_next.period_top    = cfg_data[CNT_W-1:0];
                REG_DUTY_STEP:     cfg_next.duty_step     = cfg_data[CNT_W-1:0];
                REG_DUTY_LIMIT:    cfg_next.duty_limit    = cfg_data[CNT_W-1:0];
                REG_MODE_TWO:      cfg_next.mode_two      = cfg_data[0];
                REG_POLARITY_LOW:  cfg_next.polarity_low  = cfg_data[0];
                REG_OUTPUT_ENABLE: cfg_next.output_enable = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescale_div  <= RST_PRESCALE_DIV;
            cfg_reg.period_top    <= RST_PERIOD_TOP;
            cfg_reg.duty_step     <= RST_DUTY_STEP;
            cfg_reg.duty_limit    <= RST_DUTY_LIMIT;
            cfg_reg.mode_two      <= RST_MODE_TWO;
            cfg_reg.polarity_low  <= RST_POLARITY_LOW;
            cfg_reg.output_enable <= RST_OUTPUT_EN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpwm_counter.sv
// ============================================================================
// bpwm_counter
// Prescaler and wrapping up-counter; flags the update event on a wrap.
// ============================================================================
`default_nettype none

module bpwm_counter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic                        enable,
    input  wire logic [bpwm_pkg::PRE_W-1:0]  prescale_div,
    input  wire logic [bpwm_pkg::CNT_W-1:0]  period_top,
    output logic      [bpwm_pkg::CNT_W-1:0]  main_count_next,
    output logic                             update
);
    import bpwm_pkg::*;

    logic [PRE_W-1:0] pre_count_reg;
    logic [PRE_W-1:0] pre_count_next;
    logic [CNT_W-1:0] main_count_reg;
    logic             pre_hit;
    logic             tick;

    // at or beyond the divider/top also restarts (registers may be lowered)
    assign pre_hit = (pre_count_reg >= prescale_div);
    assign tick    = enable && pre_hit;
    assign update  = tick && (main_count_reg >= period_top);

    always_comb
    begin
        pre_count_next = pre_count_reg;
        if (enable)
            pre_count_next = pre_hit ? '0 : pre_count_reg + PRE_W'(1);

        main_count_next = main_count_reg;
        if (update)
            main_count_next = '0;
        else if (tick)
            main_count_next = main_count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_count_reg  <= '0;
            main_count_reg <= '0;
        end
        else if (step)
        begin
            pre_count_reg  <= pre_count_next;
            main_count_reg <= main_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpwm_ramp.sv
// ============================================================================
// bpwm_ramp
// Active/preload compare pair with the triangle ramp of the preload.
// ============================================================================
`default_nettype none

module bpwm_ramp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [bpwm_pkg::CNT_W-1:0]  duty_step,
    input  wire logic [bpwm_pkg::CNT_W-1:0]  duty_limit,
    output logic      [bpwm_pkg::CNT_W-1:0]  compare_next,
    output logic                             down_next
);
    import bpwm_pkg::*;

    localparam int RAMP_W = CNT_W + 2;

    logic [CNT_W-1:0]         active_reg;
    logic [CNT_W-1:0]         preload_reg;
    logic [CNT_W-1:0]         preload_next;
    logic                     down_reg;
    logic                     ramp_down;
    logic signed [RAMP_W-1:0] pre_s;
    logic signed [RAMP_W-1:0] step_s;
    logic signed [RAMP_W-1:0] lim_s;
    logic signed [RAMP_W-1:0] sum_s;

    always_comb
    begin
        pre_s  = $signed({2'b00, preload_reg});
        step_s = $signed({2'b00, duty_step});
        lim_s  = $signed({2'b00, duty_limit});
        sum_s  = down_reg ? (pre_s - step_s) : (pre_s + step_s);

        // upper clamp wins over the zero clamp
        if (sum_s >= lim_s)
        begin
            preload_next = duty_limit;
            ramp_down    = 1'b1;
        end
        else if (sum_s[RAMP_W-1] || (sum_s == '0))
        begin
            preload_next = '0;
            ramp_down    = 1'b0;
        end
        else
        begin
            preload_next = sum_s[CNT_W-1:0];
            ramp_down    = down_reg;
        end
    end

    assign compare_next = load ? preload_reg : active_reg;
    assign down_next    = load ? ramp_down : down_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= INIT_PULSE;
            preload_reg <= INIT_PULSE;
            down_reg    <= 1'b1;
        end
        else if (load)
        begin
            active_reg  <= preload_reg;
            preload_reg <= preload_next;
            down_reg    <= ramp_down;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/breathing_pwm_generator_core.sv
// ============================================================================
// breathing_pwm_generator_core
// Edge-aligned PWM timer whose compare value ramps up and down as a triangle.
// ============================================================================
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, count_enable         | in
//  out     | out_valid, out_stall, pwm_out,           | out
//          | update_event, duty_now, ramping_down     |
//  cfg     | cfg_valid, cfg_ready, cfg_index,cfg_data | in
//
//  One tick per cycle sustained while out_stall is low; a tick passes from
//  input transfer through the input register, then the result register.
//  Timer state moves when the input register hands its tick to the result
//  register, so ticks are processed strictly in order.
//  in_stall rises only while the result register is full and out_stall holds.
//  Reset restores register defaults, zero counts, compare 1000, ramp down.
// ============================================================================
`default_nettype none

module breathing_pwm_generator_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            count_enable,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 pwm_out,
    output logic                                 update_event,
    output logic      [bpwm_pkg::CNT_W-1:0]      duty_now,
    output logic                                 ramping_down,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpwm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bpwm_pkg::*;

    cfg_t             cfg;
    logic             s1_valid_reg;
    logic             s1_en_reg;
    logic             out_valid_reg;
    logic             pwm_reg;
    logic             update_reg;
    logic [CNT_W-1:0] duty_reg;
    logic             down_reg;
    logic             out_free;
    logic             advance;
    logic             in_xfer;
    logic [CNT_W-1:0] main_count_next;
    logic             update;
    logic [CNT_W-1:0] compare_next;
    logic             down_next;
    logic             active;
    logic             level_next;

    bpwm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    bpwm_counter u_counter (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .enable          (s1_en_reg),
        .prescale_div    (cfg.prescale_div),
        .period_top      (cfg.period_top),
        .main_count_next (main_count_next),
        .update          (update)
    );

    bpwm_ramp u_ramp (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && update),
        .duty_step    (cfg.duty_step),
        .duty_limit   (cfg.duty_limit),
        .compare_next (compare_next),
        .down_next    (down_next)
    );

    // mode 2: active from compare upwards; mode 1: active below compare
    always_comb
    begin
        if (cfg.mode_two)
            active = (main_count_next >= compare_next);
        else
            active = (main_count_next < compare_next);
        level_next = cfg.output_enable && (active ^ cfg.polarity_low);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_en_reg <= count_enable;
        if (advance)
        begin
            pwm_reg    <= level_next;
            update_reg <= update;
            duty_reg   <= compare_next;
            down_reg   <= down_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pwm_out      = pwm_reg;
    assign update_event = update_reg;
    assign duty_now     = duty_reg;
    assign ramping_down = down_reg;

endmodule

`default_nettype wire

FILE: rtl/bpwm_checker.sv
// ============================================================================
// bpwm_checker
// Port-level checks of the breathing PWM core, bound to the top level.
// ============================================================================
`default_nettype none

module bpwm_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic                            pwm_out,
    input  wire logic                            update_event,
    input  wire logic [bpwm_pkg::CNT_W-1:0]      duty_now,
    input  wire logic                            ramping_down,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready
);
    import bpwm_pkg::*;

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pwm_out)
            && $stable(update_event) && $stable(duty_now) && $stable(ramping_down))
        else $error("result changed while stalled");

    // input back-pressure only comes from a blocked result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    // an accepted tick followed by a free output shows a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall |=> out_valid)
        else $error("accepted tick produced no result");

    // register writes are never held off
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind breathing_pwm_generator_core bpwm_checker u_bpwm_checker (.*);

`default_nettype wire

FILE: test/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the breathing PWM core. A short scripted sequence
// covers the extremes and corner cases. Random phases follow, each with its
// own register settings. Every result transfer is checked against a cycle
// model of the timer, prescaler and duty ramp. Both channels idle at random.
// ============================================================================
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpwm_pkg::*;

    localparam int TOTAL_TICKS = 1450;
    localparam int QUIET_TICKS = 150;
    localparam int NUM_ROWS    = 39;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic             pwm_out;
        logic             update_event;
        logic [CNT_W-1:0] duty_now;
        logic             ramping_down;
    } pwm_result_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  ce;
        logic                  typed;
        pwm_result_t           want;
    } row_t;

    localparam pwm_result_t AT_RESET = '{1'b0, 1'b0, INIT_PULSE, 1'b1};

    localparam row_t SCRIPT [NUM_ROWS] = '{
        '{ROW_TICK,  '0,                '0,       1'b0, 1'b1, AT_RESET},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b1, AT_RESET},
        // prescaler count now above the new divider
        '{ROW_WRITE, REG_PRESCALE_DIV,  16'h0000, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PERIOD_TOP,    16'h0002, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_DUTY_STEP,     16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_UNUSED,        16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        // zero limit: ramp pinned at zero
        '{ROW_WRITE, REG_DUTY_LIMIT,    16'h0000, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_PERIOD_TOP,    16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_DUTY_STEP,     16'h0000, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_DUTY_LIMIT,    16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_MODE_TWO,      16'h0000, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        // counter left above the lowered top
        '{ROW_WRITE, REG_PERIOD_TOP,    16'h0001, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_POLARITY_LOW,  16'h0001, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_PRESCALE_DIV,  16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_PRESCALE_DIV,  16'h0001, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_OUTPUT_ENABLE, 16'h0000, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_OUTPUT_ENABLE, 16'h0001, 1'b0, 1'b0, '0},
        '{ROW_TICK,  '0,                '0,       1'b1, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  count_enable;
    logic                  out_valid;
    logic                  out_stall;
    logic                  pwm_out;
    logic                  update_event;
    logic [CNT_W-1:0]      duty_now;
    logic                  ramping_down;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // timer model
    cfg_t             regs;
    logic [PRE_W-1:0] pre_cnt;
    logic [CNT_W-1:0] main_cnt;
    logic [CNT_W-1:0] cmp_active;
    logic [CNT_W-1:0] cmp_preload;
    logic             ramp_down;

    pwm_result_t expected_q [$];
    pwm_result_t got;
    pwm_result_t want;

    int  errors;
    int  ticks_sent;
    int  results_seen;
    int  updates_seen;
    int  phases;
    int  stall_left;
    bit  gaps_on;
    bit  stall_on;

    breathing_pwm_generator_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .count_enable (count_enable),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pwm_out      (pwm_out),
        .update_event (update_event),
        .duty_now     (duty_now),
        .ramping_down (ramping_down),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint exp, input longint act);
        $display("ERROR @%0t: %s: expected %0d, got %0d", $time, what, exp, act);
        errors++;
    endtask

    // Advance the model by one tick and return what the core should show.
    function automatic pwm_result_t step_timer(input logic ce);
        pwm_result_t r;
        logic        act;
        int          nxt;
        r = '0;
        if (ce)
        begin
            if (pre_cnt >= regs.prescale_div)
            begin
                pre_cnt = '0;
                if (main_cnt >= regs.period_top)
                begin
                    main_cnt       = '0;
                    r.update_event = 1'b1;
                end
                else
                    main_cnt = main_cnt + 1'b1;
            end
            else
                pre_cnt = pre_cnt + 1'b1;
        end
        if (r.update_event)
        begin
            cmp_active = cmp_preload;
            nxt = ramp_down ? int'(cmp_preload) - int'(regs.duty_step)
                            : int'(cmp_preload) + int'(regs.duty_step);
            // limit takes priority over the floor
            if (nxt >= int'(regs.duty_limit))
            begin
                nxt       = int'(regs.duty_limit);
                ramp_down = 1'b1;
            end
            else if (nxt <= 0)
            begin
                nxt       = 0;
                ramp_down = 1'b0;
            end
            cmp_preload = nxt[CNT_W-1:0];
        end
        act = regs.mode_two ? (main_cnt >= cmp_active) : (main_cnt < cmp_active);
        r.pwm_out      = regs.output_enable & (act ^ regs.polarity_low);
        r.duty_now     = cmp_active;
        r.ramping_down = ramp_down;
        return r;
    endfunction

    // Mostly small values so that wraps and clamps come often; extremes now and then.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input cfg_idx_t r);
        int roll;
        int lo_max;
        int hi_max;
        roll = $urandom_range(0, 19);
        case (r)
            REG_PRESCALE_DIV: begin lo_max = 0;  hi_max = 4;  end
            REG_PERIOD_TOP:   begin lo_max = 12; hi_max = 40; end
            REG_DUTY_STEP:    begin lo_max = 6;  hi_max = 30; end
            REG_DUTY_LIMIT:   begin lo_max = 20; hi_max = 60; end
            default:          return CFG_DATA_W'($urandom);
        endcase
        if (roll < 12)
            return CFG_DATA_W'($urandom_range(0, lo_max));
        else if (roll < 16)
            return CFG_DATA_W'($urandom_range(lo_max + 1, hi_max));
        else if (roll < 18)
            return '0;
        else if (roll == 18)
            return '1;
        return CFG_DATA_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PRESCALE_DIV:  regs.prescale_div  = data;
            REG_PERIOD_TOP:    regs.period_top    = data;
            REG_DUTY_STEP:     regs.duty_step     = data;
            REG_DUTY_LIMIT:    regs.duty_limit    = data;
            REG_MODE_TWO:      regs.mode_two      = data[0];
            REG_POLARITY_LOW:  regs.polarity_low  = data[0];
            REG_OUTPUT_ENABLE: regs.output_enable = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic ce, input logic typed, input pwm_result_t typed_res);
        pwm_result_t res;
        int          gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        count_enable <= ce;
        do
            @(posedge clk);
        while (in_stall);
        res = step_timer(ce);
        expected_q.push_back(typed ? typed_res : res);
        ticks_sent++;
    endtask

    // Every tick gives a result, so an empty queue means the core is idle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left == 0 && stall_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{pwm_out, update_event, duty_now, ramping_down};
            if (expected_q.size() == 0)
                report_mismatch("result transfer with nothing expected", 0, 1);
            else
            begin
                want = expected_q.pop_front();
                if (got.pwm_out !== want.pwm_out)
                    report_mismatch("pwm_out", want.pwm_out, got.pwm_out);
                if (got.update_event !== want.update_event)
                    report_mismatch("update_event", want.update_event, got.update_event);
                if (got.duty_now !== want.duty_now)
                    report_mismatch("duty_now", want.duty_now, got.duty_now);
                if (got.ramping_down !== want.ramping_down)
                    report_mismatch("ramping_down", want.ramping_down, got.ramping_down);
            end
            results_seen++;
            if (got.update_event === 1'b1)
                updates_seen++;
        end
    end

    initial
    begin
        #3_000_000;
        $display("ERROR: run timed out with %0d results outstanding", expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        cfg_idx_t r;
        int       n;
        bit       quiet;

        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        count_enable = 1'b0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        errors       = 0;
        ticks_sent   = 0;
        results_seen = 0;
        updates_seen = 0;
        phases       = 0;
        stall_left   = 0;
        gaps_on      = 1'b1;
        stall_on     = 1'b1;

        regs = '{RST_PRESCALE_DIV, RST_PERIOD_TOP, RST_DUTY_STEP, RST_DUTY_LIMIT,
                 RST_MODE_TWO, RST_POLARITY_LOW, RST_OUTPUT_EN};
        pre_cnt     = '0;
        main_cnt    = '0;
        cmp_active  = INIT_PULSE;
        cmp_preload = INIT_PULSE;
        ramp_down   = 1'b1;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(SCRIPT[i].idx, SCRIPT[i].data);
            end
            else
                send_tick(SCRIPT[i].ce, SCRIPT[i].typed, SCRIPT[i].want);
        end

        while (ticks_sent < TOTAL_TICKS)
        begin
            quiet    = (ticks_sent >= TOTAL_TICKS - QUIET_TICKS);
            gaps_on  = !quiet && ($urandom_range(0, 3) != 0);
            stall_on = !quiet && ($urandom_range(0, 3) != 0);
            wait_idle();
            r = r.first();
            repeat (r.num())
            begin
                if ($urandom_range(0, 1))
                    write_reg(r, pick_setting(r));
                r = r.next();
            end
            if ($urandom_range(0, 15) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            n = $urandom_range(20, 60);
            repeat (n)
                send_tick($urandom_range(0, 7) != 0, 1'b0, '0);
            phases++;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("results never delivered", 0, expected_q.size());

        $display("Covered %0d ticks over %0d random register settings plus the scripted cases.",
                 ticks_sent, phases);
        $display("Checked %0d result transfers, %0d of them update events.",
                 results_seen, updates_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
